>>> sv/ehs_pkg.sv
`default_nettype none
package ehs_pkg;

  localparam int unsigned EhsLog2Buckets = 10;
  localparam int unsigned EhsBucketDepth = 4;
  localparam int unsigned EhsHashWidth   = 64;

  localparam logic [31:0] EhsKey = 32'h27220A95;
  localparam int unsigned EhsRot = 5;

  localparam logic [3:0] EhsIndexBitsRst = 4'd10;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_MUL1  = 9'b000000100,
    ST_MUL2  = 9'b000001000,
    ST_CRD   = 9'b000010000,
    ST_CNT   = 9'b000100000,
    ST_SRD   = 9'b001000000,
    ST_SCMP  = 9'b010000000,
    ST_RESP  = 9'b100000000
  } ehs_state_e;

endpackage
`default_nettype wire

>>> sv/edge_hash_set.sv
`default_nettype none
// Channel  | Direction | Handshake                 | Payload
// config   | in        | cfg_we_i                  | cfg_wdata_i (index_bits)
// request  | in        | in_valid_i / in_ready_o   | cmd_i, edge_lo_i, edge_hi_i
// response | out       | out_valid_o / out_ready_i | found_o, status_o, bucket_o
//
// One 32x32 multiplier is used twice per transaction (hash), then the count
// RAM is read once. Insert: the edge is written at the count read, unless the
// bucket is full. Query: k <= n entries compared up to the first hit, one edge
// RAM read and compare per entry.
// After reset a clearing pass zeroes every count RAM entry, with in_ready_o
// low. A stalled response holds the sequencer in its last step.
module edge_hash_set #(
  parameter int unsigned LOG2_BUCKETS = ehs_pkg::EhsLog2Buckets,
  parameter int unsigned BUCKET_DEPTH = ehs_pkg::EhsBucketDepth,
  parameter int unsigned HASH_WIDTH   = ehs_pkg::EhsHashWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [3:0]              cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [31:0]             edge_lo_i,
  input  logic [31:0]             edge_hi_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    found_o,
  output logic                    status_o,
  output logic [LOG2_BUCKETS-1:0] bucket_o
);

  import ehs_pkg::*;

  localparam int unsigned NB  = 1 << LOG2_BUCKETS;
  localparam int unsigned ND  = NB * BUCKET_DEPTH;
  localparam int unsigned AW  = (ND > 1) ? $clog2(ND) : 1;
  localparam int unsigned CW  = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned LB  = LOG2_BUCKETS;

  ehs_state_e state_q, state_d;

  logic [3:0]          index_bits_q;
  logic                cmd_q, cmd_d;
  logic [31:0]         lo_q, lo_d, hi_q, hi_d;
  logic [HASH_WIDTH-1:0] prod_q, prod_d;
  logic [LB-1:0]       bucket_q, bucket_d;
  logic [LB-1:0]       clr_q, clr_d;
  logic [CW-1:0]       n_q, n_d, idx_q, idx_d;
  logic                res_found_q, res_found_d, res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  logic                out_found_q, out_found_d, out_status_q, out_status_d;
  logic [LB-1:0]       out_bucket_q, out_bucket_d;

  logic [31:0]         mul_a;
  logic [63:0]         mul_p;
  logic [HASH_WIDTH-1:0] rot, mixed;
  logic [4:0]          eff_bits;
  logic [LB:0]         mask_w;
  logic [LB-1:0]       mask;

  logic                cnt_we;
  logic [LB-1:0]       cnt_waddr;
  logic [CW-1:0]       cnt_wdata, cnt_rdata;
  logic                edg_we;
  logic [AW-1:0]       base, edg_waddr, edg_raddr;
  logic [63:0]         edg_rdata;

  // shared multiplier
  assign mul_p = {32'd0, mul_a} * {32'd0, EhsKey};

  assign rot   = {prod_q[HASH_WIDTH-EhsRot-1:0], prod_q[HASH_WIDTH-1:HASH_WIDTH-EhsRot]};
  assign mixed = rot ^ HASH_WIDTH'(hi_q);

  assign eff_bits = ({1'b0, index_bits_q} > 5'(LB)) ? 5'(LB) : {1'b0, index_bits_q};
  assign mask_w   = ((LB + 1)'(1) << eff_bits) - (LB + 1)'(1);
  assign mask     = mask_w[LB-1:0];

  // insert writes at the fresh count read in ST_CNT
  assign base      = AW'(bucket_q) * AW'(BUCKET_DEPTH);
  assign edg_waddr = base + AW'(cnt_rdata);
  assign edg_raddr = base + AW'(idx_q);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign status_o    = out_status_q;
  assign bucket_o    = out_bucket_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    prod_d       = prod_q;
    bucket_d     = bucket_q;
    clr_d        = clr_q;
    n_d          = n_q;
    idx_d        = idx_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_bucket_d = out_bucket_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    mul_a        = lo_q;
    cnt_we       = 1'b0;
    cnt_waddr    = bucket_q;
    cnt_wdata    = '0;
    edg_we       = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + LB'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          lo_d    = edge_lo_i;
          hi_d    = edge_hi_i;
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        mul_a   = lo_q;
        prod_d  = mul_p[HASH_WIDTH-1:0];
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        // bucket index needs only the low product bits
        mul_a    = mixed[31:0];
        bucket_d = mul_p[LB-1:0] & mask;
        state_d  = ST_CRD;
      end
      ST_CRD: begin
        state_d = ST_CNT;
      end
      ST_CNT: begin
        n_d          = cnt_rdata;
        idx_d        = '0;
        res_found_d  = 1'b0;
        res_status_d = 1'b0;
        if (cmd_q == CmdInsert) begin
          if (cnt_rdata >= CW'(BUCKET_DEPTH)) begin
            res_status_d = 1'b1;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rdata + CW'(1);
            edg_we    = 1'b1;
          end
          state_d = ST_RESP;
        end else if (cnt_rdata == '0) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_SRD;
        end
      end
      ST_SRD: begin
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        if (edg_rdata == {hi_q, lo_q}) begin
          res_found_d = 1'b1;
          state_d     = ST_RESP;
        end else if (idx_q + CW'(1) == n_q) begin
          state_d = ST_RESP;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_SRD;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_found_d  = res_found_q;
          out_status_d = res_status_q;
          out_bucket_d = bucket_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  ehs_ram #(
    .WIDTH (CW),
    .DEPTH (NB),
    .AW    (LB)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (bucket_q),
    .rdata_o (cnt_rdata)
  );

  ehs_ram #(
    .WIDTH (64),
    .DEPTH (ND),
    .AW    (AW)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edg_we),
    .waddr_i (edg_waddr),
    .wdata_i ({hi_q, lo_q}),
    .raddr_i (edg_raddr),
    .rdata_o (edg_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      index_bits_q <= EhsIndexBitsRst;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        index_bits_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    prod_q       <= prod_d;
    bucket_q     <= bucket_d;
    n_q          <= n_d;
    idx_q        <= idx_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
    out_bucket_q <= out_bucket_d;
  end

endmodule
`default_nettype wire

>>> sv/ehs_ram.sv
`default_nettype none
module ehs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> tb/tb_edge_hash_set.sv
`timescale 1ns / 1ps
module tb_edge_hash_set;
  import ehs_pkg::*;

  localparam int unsigned NumBuckets  = 1 << EhsLog2Buckets;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 6 + 2 * EhsBucketDepth + 4;
  localparam int unsigned PhaseItems  = 95;

  typedef struct packed {
    logic                      found;
    logic                      status;
    logic [EhsLog2Buckets-1:0] bucket;
  } edge_resp_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [3:0]                cfg_wdata = 4'd0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      cmd = CmdInsert;
  logic [31:0]               edge_lo = 32'd0;
  logic [31:0]               edge_hi = 32'd0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      found;
  logic                      status;
  logic [EhsLog2Buckets-1:0] bucket;

  // shadow copy of the set
  logic [3:0]  set_index_bits = EhsIndexBitsRst;
  int unsigned fill_level [NumBuckets];
  logic [63:0] stored_edges [NumBuckets * EhsBucketDepth];

  edge_resp_t  pending_resp [$];
  edge_resp_t  head_resp;
  logic [63:0] inserted_edges [$];

  bit          idle_en = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_insert = 0;
  int unsigned n_refused = 0;
  int unsigned n_query = 0;
  int unsigned n_hit = 0;
  int unsigned n_cfg = 0;

  edge_hash_set u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .edge_lo_i   (edge_lo),
    .edge_hi_i   (edge_hi),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .found_o     (found),
    .status_o    (status),
    .bucket_o    (bucket)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               pending_resp.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [63:0] edge_hash(logic [31:0] lo, logic [31:0] hi);
    logic [63:0] p;
    p = 64'(lo) * 64'(EhsKey);
    p = ((p << EhsRot) | (p >> (64 - EhsRot))) ^ 64'(hi);
    return p * 64'(EhsKey);
  endfunction

  function automatic logic [EhsLog2Buckets-1:0] edge_bucket(logic [31:0] lo,
                                                            logic [31:0] hi);
    int unsigned used;
    logic [63:0] h;
    logic [63:0] mask;
    used = (set_index_bits > EhsLog2Buckets) ? EhsLog2Buckets : set_index_bits;
    h    = edge_hash(lo, hi);
    mask = (64'd1 << used) - 64'd1;
    h    = h & mask;
    return h[EhsLog2Buckets-1:0];
  endfunction

  function automatic edge_resp_t apply_edge_op(logic c, logic [31:0] lo,
                                               logic [31:0] hi);
    edge_resp_t r;
    int unsigned n;
    int unsigned base;
    r        = '0;
    r.bucket = edge_bucket(lo, hi);
    n        = fill_level[r.bucket];
    base     = r.bucket * EhsBucketDepth;
    if (c == CmdInsert) begin
      if (n >= EhsBucketDepth) begin
        r.status = 1'b1;
      end else begin
        stored_edges[base + n] = {hi, lo};
        fill_level[r.bucket]   = n + 1;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (stored_edges[base + i] == {hi, lo}) r.found = 1'b1;
      end
    end
    return r;
  endfunction

  // receiver side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_resp.size() == 0) begin
        $error("response with no transaction pending: bucket %0d", bucket);
        errors++;
      end else begin
        head_resp = pending_resp.pop_front();
        if (found !== head_resp.found) begin
          $error("found: expected %0b, got %0b", head_resp.found, found);
          errors++;
        end
        if (status !== head_resp.status) begin
          $error("status: expected %0b, got %0b", head_resp.status, status);
          errors++;
        end
        if (bucket !== head_resp.bucket) begin
          $error("bucket: expected %0d, got %0d", head_resp.bucket, bucket);
          errors++;
        end
      end
    end
  end

  task automatic send_edge_op(input logic c, input logic [31:0] lo,
                              input logic [31:0] hi);
    int unsigned gap;
    edge_resp_t r;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    edge_lo  <= lo;
    edge_hi  <= hi;
    do @(posedge clk); while (!in_ready);
    r = apply_edge_op(c, lo, hi);
    pending_resp.push_back(r);
    if (c == CmdInsert) begin
      n_insert++;
      if (r.status) n_refused++;
    end else begin
      n_query++;
      if (r.found) n_hit++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_index_bits(input logic [3:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we         <= 1'b0;
    set_index_bits = v;
    n_cfg++;
  endtask

  function automatic logic [31:0] rand_vertex();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return $urandom_range(0, 255);
    if (r == 1) return 32'hFFFF_FFFF - $urandom_range(0, 255);
    return $urandom;
  endfunction

  task automatic test_extremes();
    send_edge_op(CmdQuery, 32'd0, 32'd0);
    send_edge_op(CmdInsert, 32'd0, 32'd0);
    send_edge_op(CmdInsert, 32'd0, 32'd0);  // duplicate is stored again
    send_edge_op(CmdQuery, 32'd0, 32'd0);
    send_edge_op(CmdInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_edge_op(CmdQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_edge_op(CmdInsert, 32'd0, 32'hFFFF_FFFF);
    send_edge_op(CmdQuery, 32'hFFFF_FFFF, 32'd0);  // swapped vertices
    send_edge_op(CmdQuery, 32'd0, 32'hFFFF_FFFF);
    send_edge_op(CmdInsert, 32'hFFFF_FFFF, 32'd0);
  endtask

  // fill one bucket past its depth with colliding edges, then query each
  task automatic test_full_bucket();
    logic [31:0] lo_v [EhsBucketDepth + 1];
    logic [31:0] hi_v [EhsBucketDepth + 1];
    logic [EhsLog2Buckets-1:0] target;
    int unsigned k;
    lo_v[0] = $urandom;
    hi_v[0] = $urandom;
    target  = edge_bucket(lo_v[0], hi_v[0]);
    k = 1;
    while (k <= EhsBucketDepth) begin
      lo_v[k] = $urandom;
      hi_v[k] = $urandom;
      if (edge_bucket(lo_v[k], hi_v[k]) == target) k++;
    end
    for (int i = 0; i <= EhsBucketDepth; i++) send_edge_op(CmdInsert, lo_v[i], hi_v[i]);
    for (int i = 0; i <= EhsBucketDepth; i++) send_edge_op(CmdQuery, lo_v[i], hi_v[i]);
  endtask

  // zero index bits, oversized index bits, stale placement after a change
  task automatic test_index_bits_limits();
    logic [31:0] lo;
    logic [31:0] hi;
    lo = $urandom;
    hi = $urandom;
    write_index_bits(4'd0);
    send_edge_op(CmdInsert, lo, hi);
    send_edge_op(CmdQuery, lo, hi);
    write_index_bits(4'd15);
    send_edge_op(CmdQuery, lo, hi);
    send_edge_op(CmdInsert, lo, hi);
  endtask

  task automatic test_random_sweep();
    logic [3:0]  settings [17] = '{4'd10, 4'd15, 4'd0, 4'd11, 4'd1, 4'd12, 4'd3,
                                   4'd2, 4'd13, 4'd5, 4'd4, 4'd14, 4'd6, 4'd7,
                                   4'd8, 4'd9, 4'd10};
    int unsigned r;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [63:0] e;
    foreach (settings[p]) begin
      write_index_bits(settings[p]);
      idle_en = ($urandom_range(0, 3) != 0);
      repeat (PhaseItems) begin
        r = $urandom_range(0, 99);
        if (r < 45 || inserted_edges.size() == 0) begin
          lo = rand_vertex();
          hi = rand_vertex();
          inserted_edges.push_back({hi, lo});
          send_edge_op(CmdInsert, lo, hi);
        end else if (r < 85) begin
          e = inserted_edges[$urandom_range(0, inserted_edges.size() - 1)];
          send_edge_op(CmdQuery, e[31:0], e[63:32]);
        end else begin
          send_edge_op(CmdQuery, rand_vertex(), rand_vertex());
        end
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    foreach (fill_level[i]) fill_level[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_full_bucket();
    test_index_bits_limits();
    test_random_sweep();
    wait_drained();
    $display("covered %0d inserts (%0d refused, bucket full) and %0d queries (%0d hits)",
             n_insert, n_refused, n_query, n_hit);
    $display("across %0d index_bits writes, zero and oversized settings included", n_cfg);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
